[rtl/assert_macros.svh]
// Assertion macros used by the controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr in the same cycle
`define ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that cond implies expr in the next cycle
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/mtp_pkg.sv]
// Shared constants, tables and helpers for the move-to-pose controller
package mtp_pkg;

    // CORDIC datapath widths
    localparam int CORD_IN_W = 18;
    localparam int CORD_XW   = 28;
    localparam int CORD_ZW   = 26;
    localparam int ATAN_LEN  = 24;

    // Arctangent of 2^-i in 2^-16 degree, rounded
    localparam logic signed [CORD_ZW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    localparam logic signed [CORD_ZW-1:0] DEG90_Z  = 26'sd5898240;
    localparam logic signed [CORD_ZW:0]   DEG360_Z = 27'sd23592960;

    // Square root datapath
    localparam int SQ_W   = 35;
    localparam int ROOT_W = 17;

    // cmd * 12000 / 127 as (cmd * MV_SCALE) >> MV_SHIFT, exact for |cmd| <= 127
    localparam int          MV_SHIFT = 28;
    localparam logic [34:0] MV_SCALE = 35'd25363992000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TARGET_X        = 3'd0,
        REG_TARGET_Y        = 3'd1,
        REG_TARGET_HEADING  = 3'd2,
        REG_ARC_RADIUS      = 3'd3,
        REG_LINEAR_GAIN     = 3'd4,
        REG_TURN_GAIN       = 3'd5,
        REG_FINAL_TOLERANCE = 3'd6,
        REG_NEAR_TOLERANCE  = 3'd7
    } cfg_index_t;

    // Difference a - b in degrees, wrapped once into +-180
    function automatic logic signed [10:0] min_angle(input logic [8:0] a,
                                                     input logic [8:0] b);
        logic signed [10:0] d;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        if (d > 11'sd180)
            d = d - 11'sd360;
        else if (d < -11'sd180)
            d = d + 11'sd360;
        return d;
    endfunction

endpackage

[rtl/mtp_delay.sv]
// Fixed-length enabled delay line for side data
module mtp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    // Shift one tap per advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

[rtl/mtp_isqrt.sv]
// Pipelined floor square root, one result bit per stage
module mtp_isqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [mtp_pkg::SQ_W-1:0]  radicand,
    output logic [mtp_pkg::ROOT_W-1:0] root
);
    import mtp_pkg::*;

    logic [SQ_W-1:0] rem_reg [1:ROOT_W];
    logic [SQ_W-1:0] acc_reg [1:ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        localparam int SH = 2 * (ROOT_W - 1 - j);
        logic [SQ_W-1:0] rem_cur;
        logic [SQ_W-1:0] acc_cur;
        logic [SQ_W-1:0] trial;
        logic            take;

        if (j == 0)
        begin : g_first
            assign rem_cur = radicand;
            assign acc_cur = '0;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[j];
            assign acc_cur = acc_reg[j];
        end

        assign trial = acc_cur + (SQ_W'(1) << SH);
        assign take  = (rem_cur >= trial);

        // Advance the partial root
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (take)
                    acc_reg[j+1] <= (acc_cur >> 1) + (SQ_W'(1) << SH);
                else
                    acc_reg[j+1] <= acc_cur >> 1;
            end
        end

        // Advance the remainder except after the last step
        if (j < ROOT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (take)
                        rem_reg[j+1] <= rem_cur - trial;
                    else
                        rem_reg[j+1] <= rem_cur;
                end
            end
        end
    end

    assign root = acc_reg[ROOT_W][ROOT_W-1:0];

endmodule

[rtl/mtp_cordic.sv]
// Pipelined CORDIC vectoring unit: atan2(num, den) in 2^-16 degree
module mtp_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [mtp_pkg::CORD_IN_W-1:0] num,
    input  logic signed [mtp_pkg::CORD_IN_W-1:0] den,
    output logic signed [mtp_pkg::CORD_ZW-1:0]   angle
);
    import mtp_pkg::*;

    logic signed [CORD_XW-1:0] x_reg [0:STAGES];
    logic signed [CORD_XW-1:0] y_reg [0:STAGES];
    logic signed [CORD_ZW-1:0] z_reg [0:STAGES];
    logic                      zero_reg [0:STAGES];

    logic signed [CORD_XW-1:0] x_in;
    logic signed [CORD_XW-1:0] y_in;
    logic signed [CORD_XW-1:0] x_pre;
    logic signed [CORD_XW-1:0] y_pre;
    logic signed [CORD_ZW-1:0] z_pre;

    // Scale and rotate the left half plane by +-90 degrees
    always_comb
    begin
        x_in  = CORD_XW'(den) <<< 8;
        y_in  = CORD_XW'(num) <<< 8;
        x_pre = x_in;
        y_pre = y_in;
        z_pre = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_pre = y_in;
                y_pre = -x_in;
                z_pre = DEG90_Z;
            end
            else
            begin
                x_pre = -y_in;
                y_pre = x_in;
                z_pre = -DEG90_Z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            z_reg[0]    <= z_pre;
            zero_reg[0] <= (num == '0) && (den == '0);
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign angle = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

[rtl/move_to_pose_drive_controller_top.sv]
// Top level of the move-to-pose drive controller pipeline
// The block takes one pose beat per cycle while the pipeline is not stalled
// and returns one drive beat per pose, in order. The distance comes from the
// 17-stage square root, followed by the second CORDIC that forms the approach
// angle and six stages of error, gain, saturation and millivolt scaling. The
// whole pipeline advances together: it stalls only while a finished drive beat
// is held at the output, and s_tready is low for exactly those cycles. Write
// target and gain registers only while the pipeline is empty.
`include "assert_macros.svh"

module move_to_pose_drive_controller_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Pose input: [15:0] pos_x, [31:16] pos_y, [40:32] heading, [47:41] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Drive output: [14:0] left_millivolts, [29:15] right_millivolts, [31:30] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Drive flags: [0] arrived
    output logic        m_tuser
);
    import mtp_pkg::*;

    localparam int CS    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int LAT   = CS + 1;
    localparam int TOTAL = LAT + 26;

    // Helpers for the command path
    function automatic logic signed [7:0] cmd_of(input logic signed [34:0] s);
        logic signed [34:0] t;
        t = (s + ((s < 0) ? 35'sd4095 : 35'sd0)) >>> 12;
        if (t > 35'sd127)
            return 8'sd127;
        else if (t < -35'sd127)
            return -8'sd127;
        return t[7:0];
    endfunction

    function automatic logic signed [14:0] mv_of(input logic signed [7:0] c);
        logic [6:0]  mag;
        logic [42:0] prod;
        logic [13:0] q;
        mag  = (c < 0) ? 7'(-c) : 7'(c);
        prod = 43'(mag) * 43'(MV_SCALE);
        q    = prod[41:28];
        return (c < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Configuration registers
    logic signed [15:0] tx_reg;
    logic signed [15:0] ty_reg;
    logic [8:0]         th_reg;
    logic [11:0]        rad_reg;
    logic [15:0]        lg_reg;
    logic [15:0]        tg_reg;
    logic [11:0]        ftol_reg;
    logic [11:0]        ntol_reg;

    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg   <= '0;
            ty_reg   <= '0;
            th_reg   <= '0;
            rad_reg  <= '0;
            lg_reg   <= 16'd256;
            tg_reg   <= 16'd256;
            ftol_reg <= 12'd16;
            ntol_reg <= 12'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_TARGET_X:        tx_reg   <= $signed(cfg_data);
                REG_TARGET_Y:        ty_reg   <= $signed(cfg_data);
                REG_TARGET_HEADING:  th_reg   <= cfg_data[8:0];
                REG_ARC_RADIUS:      rad_reg  <= cfg_data[11:0];
                REG_LINEAR_GAIN:     lg_reg   <= cfg_data;
                REG_TURN_GAIN:       tg_reg   <= cfg_data;
                REG_FINAL_TOLERANCE: ftol_reg <= cfg_data[11:0];
                REG_NEAR_TOLERANCE:  ntol_reg <= cfg_data[11:0];
                default:             ;
            endcase
        end
    end

    // Pipeline advance and valid tracking
    logic             en;
    logic [TOTAL-1:0] vld_reg;

    assign en       = !vld_reg[TOTAL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid};
    end

    // Stage 1: offsets to target and folded final heading error
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic [8:0]         in_hd;
    logic signed [10:0] fa;
    logic signed [10:0] ff;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic [8:0]         hd_reg;
    logic signed [7:0]  fold_reg;

    assign in_x  = $signed(s_tdata[15:0]);
    assign in_y  = $signed(s_tdata[31:16]);
    assign in_hd = s_tdata[40:32];

    always_comb
    begin
        fa = min_angle(th_reg, in_hd);
        ff = fa;
        if (fa > 11'sd90)
            ff = fa - 11'sd180;
        else if (fa < -11'sd90)
            ff = fa + 11'sd180;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= 17'(tx_reg) - 17'(in_x);
            dy_reg   <= 17'(ty_reg) - 17'(in_y);
            hd_reg   <= in_hd;
            fold_reg <= ff[7:0];
        end
    end

    // Stages 2-3: squared distance
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [32:0]        dxsq_reg;
    logic [32:0]        dysq_reg;
    logic [33:0]        sumsq_reg;

    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxsq_reg  <= dx_sq[32:0];
            dysq_reg  <= dy_sq[32:0];
            sumsq_reg <= 34'(dxsq_reg) + 34'(dysq_reg);
        end
    end

    // Distance, ready at stage 20
    logic [ROOT_W-1:0] dist_w;

    mtp_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, sumsq_reg}),
        .root     (dist_w)
    );

    // Bearing CORDIC, ready at stage LAT+1
    logic signed [CORD_ZW-1:0] z1_w;

    mtp_cordic #(.STAGES(CS)) u_cordic_bearing (
        .clk   (clk),
        .en    (en),
        .num   (CORD_IN_W'(dx_reg)),
        .den   (CORD_IN_W'(dy_reg)),
        .angle (z1_w)
    );

    // Approach angle CORDIC, ready at stage LAT+20
    logic signed [CORD_ZW-1:0] z2_w;

    mtp_cordic #(.STAGES(CS)) u_cordic_approach (
        .clk   (clk),
        .en    (en),
        .num   ($signed({6'b000000, rad_reg})),
        .den   ($signed({1'b0, dist_w})),
        .angle (z2_w)
    );

    // Heading delayed to the bearing stage
    logic [8:0] hd_d;

    mtp_delay #(.W(9), .DEPTH(LAT)) u_dly_hd (
        .clk (clk),
        .en  (en),
        .d   (hd_reg),
        .q   (hd_d)
    );

    // Bearing wrapped to 0..359 whole degrees
    logic signed [CORD_ZW:0] zz;
    logic [10:0]             brg_raw;
    logic [8:0]              brg_reg;
    logic [8:0]              hd_b_reg;

    always_comb
    begin
        zz      = (z1_w < 0) ? (CORD_ZW'(z1_w) + DEG360_Z) : (CORD_ZW+1)'(z1_w);
        brg_raw = zz[26:16];
        if (brg_raw >= 11'd360)
            brg_raw = brg_raw - 11'd360;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            brg_reg  <= brg_raw[8:0];
            hd_b_reg <= hd_d;
        end
    end

    // Steering errors in 1/16 degree
    logic signed [10:0] alpha_deg;
    logic signed [10:0] terr_deg;
    logic signed [13:0] alpha_reg;
    logic signed [13:0] terr_reg;

    assign alpha_deg = min_angle(brg_reg, th_reg);
    assign terr_deg  = min_angle(brg_reg, hd_b_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg <= {alpha_deg[9:0], 4'b0000};
            terr_reg  <= {terr_deg[9:0], 4'b0000};
        end
    end

    // Align errors with the approach angle
    logic [27:0]        err_d;
    logic signed [13:0] alpha_a;
    logic signed [13:0] terr_a;

    mtp_delay #(.W(28), .DEPTH(17)) u_dly_err (
        .clk (clk),
        .en  (en),
        .d   ({alpha_reg, terr_reg}),
        .q   (err_d)
    );

    assign alpha_a = $signed(err_d[27:14]);
    assign terr_a  = $signed(err_d[13:0]);

    // Tolerance flags with distance, aligned to the command stage
    logic [18:0]       dist_d;
    logic [ROOT_W-1:0] dist_c;
    logic              near_c;
    logic              arr_c;

    mtp_delay #(.W(19), .DEPTH(LAT + 2)) u_dly_dist (
        .clk (clk),
        .en  (en),
        .d   ({dist_w, (dist_w < ROOT_W'(ntol_reg)), (dist_w < ROOT_W'(ftol_reg))}),
        .q   (dist_d)
    );

    assign dist_c = dist_d[18:2];
    assign near_c = dist_d[1];
    assign arr_c  = dist_d[0];

    logic [7:0]        fold_d;
    logic signed [7:0] fold_c;

    mtp_delay #(.W(8), .DEPTH(LAT + 21)) u_dly_fold (
        .clk (clk),
        .en  (en),
        .d   (fold_reg),
        .q   (fold_d)
    );

    assign fold_c = $signed(fold_d);

    // Q1: rounded approach angle, signed like alpha
    logic signed [CORD_ZW-1:0] bz;
    logic signed [13:0]        beta_reg;
    logic signed [13:0]        alpha_q_reg;
    logic signed [13:0]        terr_q_reg;

    assign bz = (z2_w + CORD_ZW'(2048)) >>> 12;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beta_reg    <= (alpha_a < 0) ? -bz[13:0] : bz[13:0];
            alpha_q_reg <= alpha_a;
            terr_q_reg  <= terr_a;
        end
    end

    // Q2: total steering error, wrapped once
    logic signed [13:0] abs_alpha;
    logic signed [13:0] abs_beta;
    logic signed [14:0] r_sum;
    logic signed [14:0] r_wrap;
    logic signed [13:0] r_reg;

    always_comb
    begin
        abs_alpha = (alpha_q_reg < 0) ? -alpha_q_reg : alpha_q_reg;
        abs_beta  = (beta_reg < 0) ? -beta_reg : beta_reg;
        if (abs_alpha < abs_beta)
            r_sum = 15'(terr_q_reg) + 15'(alpha_q_reg);
        else
            r_sum = 15'(terr_q_reg) + 15'(beta_reg);
        r_wrap = r_sum;
        if (r_sum > 15'sd2880)
            r_wrap = r_sum - 15'sd5760;
        else if (r_sum < -15'sd2880)
            r_wrap = r_sum + 15'sd5760;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= r_wrap[13:0];
    end

    // Q3: gain products, near-target turn and drive sign
    logic signed [13:0] opnd;
    logic               lin_neg;
    logic               lin_zero;
    logic [32:0]        linp_reg;
    logic signed [30:0] turnp_reg;
    logic               lneg_reg;
    logic               lzero_reg;
    logic               arr3_reg;

    always_comb
    begin
        opnd     = r_reg;
        lin_neg  = 1'b0;
        lin_zero = 1'b0;
        if (near_c)
        begin
            opnd = 14'($signed({fold_c, 4'b0000}));
            if (r_reg == 14'sd1440 || r_reg == -14'sd1440)
                lin_zero = 1'b1;
            else if (r_reg > 14'sd1440 || r_reg < -14'sd1440)
                lin_neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            linp_reg  <= 33'(lg_reg) * 33'(dist_c);
            turnp_reg <= $signed({1'b0, tg_reg}) * opnd;
            lneg_reg  <= lin_neg;
            lzero_reg <= lin_zero;
            arr3_reg  <= arr_c;
        end
    end

    // Q4: left and right command sums
    logic signed [33:0] lin_s;
    logic signed [34:0] suml_reg;
    logic signed [34:0] sumr_reg;
    logic               arr4_reg;

    always_comb
    begin
        lin_s = $signed({1'b0, linp_reg});
        if (lzero_reg)
            lin_s = '0;
        else if (lneg_reg)
            lin_s = -lin_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            suml_reg <= 35'(lin_s) + 35'(turnp_reg);
            sumr_reg <= 35'(lin_s) - 35'(turnp_reg);
            arr4_reg <= arr3_reg;
        end
    end

    // Q5: truncate and saturate commands
    logic signed [7:0] cmdl_reg;
    logic signed [7:0] cmdr_reg;
    logic              arr5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmdl_reg <= cmd_of(suml_reg);
            cmdr_reg <= cmd_of(sumr_reg);
            arr5_reg <= arr4_reg;
        end
    end

    // Q6: scale to millivolts, zero on arrival; output register
    logic signed [14:0] left_reg;
    logic signed [14:0] right_reg;
    logic               arr6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= arr5_reg ? '0 : mv_of(cmdl_reg);
            right_reg <= arr5_reg ? '0 : mv_of(cmdr_reg);
            arr6_reg  <= arr5_reg;
        end
    end

    assign m_tdata = {2'b00, right_reg, left_reg};
    assign m_tuser = arr6_reg;

    // Checks
    `ASSERT_IMPLIES(a_arrived_zero, m_tvalid && m_tuser, m_tdata[29:0] == 30'd0,
        "arrived beat carries nonzero drive")
    `ASSERT_IMPLIES(a_mv_range, m_tvalid,
        (left_reg <= 15'sd12000) && (left_reg >= -15'sd12000)
        && (right_reg <= 15'sd12000) && (right_reg >= -15'sd12000), "drive out of range")
    `ASSERT_IMPLIES(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "input taken while output stalled")
    `ASSERT_NEXT(a_drain_empty, m_tvalid && m_tready && !vld_reg[TOTAL-2], !m_tvalid,
        "output beat appeared from an empty stage")

endmodule
